// ===== hw/rtl/cnrf_pkg.sv =====
// Package for the cubic Newton root finder: types, register indexes, status codes.
// No dependencies; every other file but cnrf_stream_if imports it.
package cnrf_pkg;
  typedef enum logic [2:0] {
    REG_COEFF_CONST  = 3'd0,
    REG_COEFF_LINEAR = 3'd1,
    REG_COEFF_SQUARE = 3'd2,
    REG_COEFF_CUBE   = 3'd3,
    REG_TOLERANCE    = 3'd4,
    REG_ITER_LIMIT   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_FLAT      = 2'd1,
    ST_LIMIT     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_PMUL, S_PADD, S_PCHK, S_DMUL, S_DADD, S_DCHK,
    S_DIV, S_UPD, S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
  } div_ctl_t;

  localparam int DATA_W = 32;
  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh80000000;
endpackage

// ===== hw/rtl/cnrf_stream_if.sv =====
// Valid/ready channel carrying one payload of parameterised type.
// Depends on nothing.
interface cnrf_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cubic_newton_root_finder.sv =====
// Top level of the cubic Newton root finder: registers, sequencer, shared
// multiplier/adder and the divider. Depends on cnrf_pkg, cnrf_stream_if, cnrf_divider.
//
// Usage: an item on the input channel carries a starting guess in Q16.16.
// The block runs Newton iterations on the cubic held in the coefficient
// registers and returns one item: the last x, a finish status and the
// number of updates made. Configuration is written through the cfg_ port
// while the block is idle; writes past the register list are ignored.
// Each iteration runs a start step, three multiply/add pairs for p, a
// check, two pairs for p', a check, a 32+FRAC_BITS-bit quotient from the
// one-bit-per-cycle divider and an update. The run ends at the limit, the
// value check or the slope check. One item is processed at a time; in_ready
// is low while it is at work. The result sits in an output register until
// taken; a stalled receiver holds the block in its done state, and the next
// guess is accepted in the cycle after the result leaves. Reset restores the
// register defaults and returns the sequencer to idle with no result pending.
module cubic_newton_root_finder #(
  parameter int FRAC_BITS = 16,
  parameter int DEGREE    = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  cnrf_stream_if.sink   in_ch,
  cnrf_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cnrf_pkg::*;

  // Powers above three are zero, so a higher degree behaves as a cubic.
  localparam int DEG_EFF = (DEGREE >= 3) ? 3 : DEGREE;

  logic signed [31:0] c_r [4];
  logic [30:0] tol_r;
  logic [7:0]  lim_r;
  state_t      st_r, st_nxt;
  logic signed [31:0] x_r, acc_r, y_r, mul_r;
  logic [1:0]  k_r;          // current Horner power index
  logic [7:0]  it_r, used_r;
  logic [1:0]  status_r;
  div_ctl_t    dctl;
  logic        ddone;
  logic signed [31:0] dq;

  // Effective coefficients honour DEGREE; derivative coefficients saturate.
  function automatic logic signed [31:0] sat64(input logic signed [65:0] v);
    if (v > 66'(SAT_MAX)) return SAT_MAX;
    if (v < 66'(SAT_MIN)) return SAT_MIN;
    return v[31:0];
  endfunction

  logic signed [31:0] pc [4];
  logic signed [31:0] dc [3];
  always_comb begin
    for (int i = 0; i < 4; i++) pc[i] = (i <= DEGREE) ? c_r[i] : '0;
    for (int i = 0; i < 3; i++) dc[i] = sat64(66'(i + 1) * 66'(pc[i+1]));
  end

  // Shared multiplier: acc * x, floor shift, saturate. Registered.
  logic signed [63:0] prod;
  logic signed [65:0] shp;
  logic signed [31:0] addend, sum;
  assign prod = acc_r * x_r;
  assign shp  = 66'(prod >>> FRAC_BITS);
  assign addend = (st_r == S_PADD) ? pc[k_r] : dc[k_r];
  assign sum  = sat64(66'(mul_r) + 66'(addend));

  logic [32:0] aabs;
  assign aabs = acc_r[31] ? 33'(-{acc_r[31], acc_r}) : {1'b0, acc_r};
  logic lt_tol;
  assign lt_tol = aabs < {2'b0, tol_r};

  cnrf_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n, .ctl(dctl), .num(y_r), .den(acc_r), .done(ddone), .quo(dq)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (in_ch.valid) st_nxt = S_START;
      S_START: st_nxt = (it_r == lim_r) ? S_DONE : S_PMUL;
      S_PMUL:  st_nxt = (k_r == 2'd0 && DEGREE == 0) ? S_PCHK : S_PADD;
      S_PADD:  st_nxt = (k_r == 2'd0) ? S_PCHK : S_PMUL;
      S_PCHK:  st_nxt = lt_tol ? S_DONE : (DEGREE >= 2 ? S_DMUL : S_DCHK);
      S_DMUL:  st_nxt = S_DADD;
      S_DADD:  st_nxt = (k_r == 2'd0) ? S_DCHK : S_DMUL;
      S_DCHK:  st_nxt = (lt_tol || acc_r == '0) ? S_DONE : S_DIV;
      S_DIV:   if (ddone) st_nxt = S_UPD;
      S_UPD:   st_nxt = S_START;
      S_DONE:  if (out_ch.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (st_r == S_IDLE);
    out_ch.valid = (st_r == S_DONE);
    out_ch.data  = {x_r, status_r, used_r};
    dctl.start   = (st_r == S_DCHK) && !(lt_tol || acc_r == '0);
  end

  logic signed [31:0] qh;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      for (int i = 0; i < 4; i++) c_r[i] <= '0;
      tol_r <= 31'd66; lim_r <= 8'd20;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_COEFF_CONST:  c_r[0] <= cfg_data;
          REG_COEFF_LINEAR: c_r[1] <= cfg_data;
          REG_COEFF_SQUARE: c_r[2] <= cfg_data;
          REG_COEFF_CUBE:   c_r[3] <= cfg_data;
          REG_TOLERANCE:    tol_r <= cfg_data[30:0];
          REG_ITER_LIMIT:   lim_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
    case (st_r)
      S_IDLE: if (in_ch.valid) begin
        x_r <= in_ch.data; it_r <= '0; used_r <= '0; status_r <= ST_LIMIT;
      end
      S_START: begin
        acc_r <= pc[DEG_EFF];
        k_r   <= 2'(DEG_EFF - 1);
      end
      S_PMUL, S_DMUL: mul_r <= sat64(shp);
      S_PADD, S_DADD: begin acc_r <= sum; k_r <= k_r - 1'b1; end
      S_PCHK: begin
        y_r <= acc_r;
        if (lt_tol) status_r <= ST_CONVERGED;
        acc_r <= dc[DEG_EFF - 1];
        k_r   <= 2'(DEG_EFF - 2);
      end
      S_DCHK: if (lt_tol || acc_r == '0) status_r <= ST_FLAT;
      S_DIV: if (ddone) qh <= dq;
      S_UPD: begin
        x_r <= sat64(66'(x_r) - 66'(qh));
        used_r <= used_r + 1'b1; it_r <= it_r + 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/cnrf_divider.sv =====
// Restoring signed divider, one quotient bit per cycle, saturated to 32 bits.
// Depends on cnrf_pkg.
module cnrf_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cnrf_pkg::div_ctl_t  ctl,
  input  logic signed [31:0]  num,
  input  logic signed [31:0]  den,
  output logic                done,
  output logic signed [31:0]  quo
);
  import cnrf_pkg::*;
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   d_r, d_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic [NW-1:0] anum;
  logic [33:0]   trial;
  logic [NW:0]   sq;

  always_comb begin
    // Magnitude of the numerator shifted up by the fraction bits.
    anum = num[31] ? {32'(-num), {FRAC_BITS{1'b0}}}
                   : {num, {FRAC_BITS{1'b0}}};
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; run_nxt = run_r;
    trial = {rem_r, q_r[NW-1]} - {2'b0, d_r};
    if (ctl.start) begin
      q_nxt = anum; rem_nxt = '0;
      d_nxt = den[31] ? 32'(-den) : den;
      neg_nxt = num[31] ^ den[31];
      cnt_nxt = CW'(NW); run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0]; q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[NW-1]}; q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; cnt_r <= '0;
    end else begin
      run_r <= run_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt;
  end

  assign done = run_r && (cnt_r == CW'(1)) && !ctl.start;
  // Final quotient bit is resolved combinationally from the last step.
  always_comb begin
    sq = neg_r ? (NW+1)'(-{1'b0, q_nxt}) : {1'b0, q_nxt};
    if (!neg_r && q_nxt > NW'(SAT_MAX)) quo = SAT_MAX;
    else if (neg_r && q_nxt > NW'(33'h80000000)) quo = SAT_MIN;
    else quo = sq[31:0];
  end
endmodule

// ===== hw/rtl/cnrf_checker.sv =====
// Port-level checker for the cubic Newton root finder, bound to the top level.
// Depends on cnrf_pkg.
module cnrf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [41:0] out_data
);
  import cnrf_pkg::*;
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data[9:8] != 2'd3) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice");
endmodule

bind cubic_newton_root_finder cnrf_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ===== tb/cnrf_root_checker.sv =====
// Checker for the cubic Newton root finder: watches the configuration port and both channels,
// predicts each root item and compares it. Depends on cnrf_pkg and cnrf_stream_if.
module cnrf_root_checker (
  input  logic        clk,
  input  logic        rst_n,
  cnrf_stream_if      in_ch,
  cnrf_stream_if      out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatch_count,
  output int          roots_pending,
  output int          roots_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import cnrf_pkg::*;

  localparam int FRAC = 16;

  typedef struct packed {
    logic signed [31:0] root_value;
    status_t            finish_status;
    logic [7:0]         iterations_used;
  } root_item_t;

  logic signed [31:0] coeff [4];
  logic [30:0]        tol_lvl;
  logic [7:0]         iter_lim;
  root_item_t         expected_roots [$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product, floored and clamped.
  function automatic longint qmul(longint a, longint b);
    return clamp32((a * b) >>> FRAC);
  endfunction

  function automatic root_item_t solve_root(logic signed [31:0] guess);
    longint c0, c1, c2, c3, d0, d1, d2, x, y, yp, q, tol;
    root_item_t r;
    int used;
    c0 = coeff[0]; c1 = coeff[1]; c2 = coeff[2]; c3 = coeff[3];
    d0 = clamp32(c1); d1 = clamp32(2 * c2); d2 = clamp32(3 * c3);
    tol = longint'(tol_lvl);
    x = guess;
    used = 0;
    r.finish_status = ST_LIMIT;
    for (int it = 0; it < int'(iter_lim); it++) begin
      y = clamp32(qmul(c3, x) + c2);
      y = clamp32(qmul(y, x) + c1);
      y = clamp32(qmul(y, x) + c0);
      if ((y < 0 ? -y : y) < tol) begin
        r.finish_status = ST_CONVERGED;
        break;
      end
      yp = clamp32(qmul(d2, x) + d1);
      yp = clamp32(qmul(yp, x) + d0);
      if ((yp < 0 ? -yp : yp) < tol || yp == 0) begin
        r.finish_status = ST_FLAT;
        break;
      end
      q = clamp32((y * 64'sd65536) / yp);
      x = clamp32(x - q);
      used++;
    end
    r.root_value = x[31:0];
    r.iterations_used = used[7:0];
    return r;
  endfunction

  always @(posedge clk) begin
    root_item_t got, want;
    if (!rst_n) begin
      coeff[0] <= '0; coeff[1] <= '0; coeff[2] <= '0; coeff[3] <= '0;
      tol_lvl <= 31'd66;
      iter_lim <= 8'd20;
      expected_roots.delete();
      mismatch_count <= 0;
      roots_pending <= 0;
      roots_checked <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_roots.push_back(solve_root(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_roots.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] unexpected root item: root %h status %0d iters %0d",
                     $realtime, got.root_value, got.finish_status, got.iterations_used);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_roots.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display({"[%0t] mismatch: exp root %h status %0d iters %0d, ",
                        "got root %h status %0d iters %0d"},
                       $realtime, want.root_value, want.finish_status,
                       want.iterations_used, got.root_value, got.finish_status,
                       got.iterations_used);
            mismatch_count <= mismatch_count + 1;
          end
          roots_checked <= roots_checked + 1;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_COEFF_CONST:  coeff[0] <= cfg_data;
          REG_COEFF_LINEAR: coeff[1] <= cfg_data;
          REG_COEFF_SQUARE: coeff[2] <= cfg_data;
          REG_COEFF_CUBE:   coeff[3] <= cfg_data;
          REG_TOLERANCE:    tol_lvl <= cfg_data[30:0];
          REG_ITER_LIMIT:   iter_lim <= cfg_data[7:0];
          default: ;
        endcase
      end
      roots_pending <= expected_roots.size();
    end
  end
endmodule

// ===== tb/tb_cubic_newton_root_finder.sv =====
// Top of the root finder testbench: clock, reset, configuration phases, guess stimulus and
// the verdict. Depends on cnrf_pkg, cnrf_stream_if, cnrf_root_checker and the block itself.
module tb_cubic_newton_root_finder;
  timeunit 1ns;
  timeprecision 1ps;
  import cnrf_pkg::*;

  // Indexes beyond the register list; writes there must leave everything unchanged.
  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;
  // Generous bound: well above the slowest legal run of this stimulus.
  localparam int CYCLE_LIMIT = 30_000_000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  cnrf_stream_if #(.payload_t(logic [31:0])) in_ch ();
  cnrf_stream_if #(.payload_t(logic [41:0])) out_ch ();

  int mismatch_count, roots_pending, roots_checked;
  int cycle_count = 0;
  int guesses_sent = 0;
  int phases_run = 0;
  bit calm = 1'b0;        // when set, neither side idles
  int hold_cycles = 0;    // receiver hold-off, counted down by the receiver process

  cubic_newton_root_finder dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cnrf_root_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .roots_pending(roots_pending),
    .roots_checked(roots_checked)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle counter doubling as the watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: random idling, or a long counted hold-off when one is requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 23);
    end
  end

  // A register write takes one cycle with the enable high.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_poly(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                          logic [31:0] c3, logic [31:0] tol, logic [31:0] lim);
    write_reg(REG_COEFF_CONST, c0);
    write_reg(REG_COEFF_LINEAR, c1);
    write_reg(REG_COEFF_SQUARE, c2);
    write_reg(REG_COEFF_CUBE, c3);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_ITER_LIMIT, lim);
  endtask

  // Offer one guess; returns after the edge at which it was accepted, valid still high.
  task automatic send_guess(logic [31:0] guess);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 23) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= guess;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    guesses_sent++;
  endtask

  // Drop valid and wait until every expected root has arrived, plus a short settle.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (roots_pending != 0 || hold_cycles != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [31:0] small_q(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2:       return '0;
      default: return small_q(4 << 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_guess();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return small_q(8 << 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_tol();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom();          // top bit is dropped by the block
      2:       return 32'h7fff_ffff;
      3:       return $urandom_range(0, 1 << 14);
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  task automatic random_phase(int n_items, logic [31:0] lim);
    set_poly(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(), rand_tol(), lim);
    // Writes past the register list must be ignored.
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI, $urandom());
    for (int i = 0; i < n_items; i++) send_guess(rand_guess());
    drain();
    phases_run++;
  endtask

  initial begin
    int remaining;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset defaults give p = 0, so every guess converges at once.
    send_guess('0);
    send_guess(32'h7fff_ffff);
    drain();

    // x^3 - 2: a regular root, a flat slope at zero, and the range extremes.
    set_poly(-(2 << 16), '0, '0, ONE, 32'd66, 32'd20);
    send_guess('0);
    send_guess(ONE);
    send_guess(-ONE);
    send_guess(32'h7fff_ffff);
    send_guess(32'h8000_0000);
    send_guess(32'hffff_ffff);
    drain();

    // Iteration limit of zero: the guess comes back unchanged.
    write_reg(REG_ITER_LIMIT, '0);
    send_guess(32'h1234_5678);
    send_guess(32'h8000_0000);
    drain();

    // Zero tolerance: only an exactly zero slope stops on flatness.
    set_poly(ONE, '0, ONE, '0, '0, 32'd20);
    send_guess('0);
    send_guess(ONE);
    send_guess(2 << 16);
    drain();

    // Extreme coefficients saturate products and the square and cube derivative terms.
    set_poly(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             32'hffff_ffff, 32'd255);
    send_guess(32'h7fff_ffff);
    send_guess(32'h8000_0000);
    send_guess(ONE);
    drain();
    write_reg(IDX_SPARE_LO, '1);
    write_reg(IDX_SPARE_HI, '0);
    send_guess(-ONE);
    drain();

    // Pressure: the receiver holds off while the sender keeps offering guesses,
    // so the block stalls in its done state and refuses new input.
    set_poly(-(2 << 16), '0, '0, ONE, 32'd66, 32'd4);
    hold_cycles = 400;
    for (int i = 0; i < 6; i++) send_guess(rand_guess());
    // The sender then waits for every outstanding root before carrying on.
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (roots_pending != 0 || hold_cycles != 0) @(negedge clk);
    for (int i = 0; i < 4; i++) send_guess(rand_guess());
    drain();

    // A long stretch with no idling on either side.
    calm = 1'b1;
    random_phase(120, $urandom_range(0, 6));
    calm = 1'b0;

    // A few guesses at the largest iteration limit.
    random_phase(4, 32'd255);

    // Random phases, mostly with small limits to keep the run short.
    remaining = 1500 - 124;
    while (remaining > 0) begin
      int n;
      n = (remaining < 60) ? remaining : $urandom_range(20, 60);
      random_phase(n, $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) & 32'hff
                                               : $urandom_range(0, 8));
      remaining -= n;
    end

    repeat (20) @(negedge clk);
    $display("Sent %0d guesses over %0d random register settings; %0d roots checked.",
             guesses_sent, phases_run, roots_checked);
    $display("Covered limit zero, zero tolerance, flat slopes, saturation and stalls.");
    if (mismatch_count == 0 && roots_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/cnrf_pkg.sv
hw/rtl/cnrf_stream_if.sv
hw/rtl/cnrf_divider.sv
hw/rtl/cubic_newton_root_finder.sv
hw/rtl/cnrf_checker.sv
tb/cnrf_root_checker.sv
tb/tb_cubic_newton_root_finder.sv
